FILE: hw/rtl/tdu_pkg.sv
// ----------------------------------------------------------------------------
// tdu_pkg
// Shared types and constants for the tick-driven uart transmitter/receiver.
// ----------------------------------------------------------------------------
package tdu_pkg;

    // default number of data bits per frame
    localparam int unsigned DATA_BITS_DEF = 8;

    // ticks per bit on the line, and ticks from start edge to first sample
    localparam logic [1:0] TX_BIT_TICKS   = 2'd3;
    localparam logic [2:0] RX_BIT_TICKS   = 3'd3;
    localparam logic [2:0] RX_START_TICKS = 3'd4;

    // transmit phase
    typedef enum logic [2:0] {
        TX_START = 3'b001,
        TX_DATA  = 3'b010,
        TX_STOP  = 3'b100
    } t_tx_phase;

    // receive phase
    typedef enum logic [2:0] {
        RX_IDLE = 3'b001,
        RX_DATA = 3'b010,
        RX_WAIT = 3'b100
    } t_rx_phase;

    // one tick as it arrives
    typedef struct packed {
        logic       rx_line;
        logic       send_request;
        logic [7:0] send_byte;
    } t_in;

    // one tick's result
    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic       send_accepted;
        logic       rx_busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_out;

    // transmitter status after the tick
    typedef struct packed {
        logic line;
        logic busy;
        logic accepted;
    } t_tx_status;

    // receiver status after the tick
    typedef struct packed {
        logic       busy;
        logic       valid;
        logic [7:0] data;
    } t_rx_status;

endpackage

FILE: hw/rtl/tdu_tx.sv
// ----------------------------------------------------------------------------
// tdu_tx
// Transmit section: start bit, data bits lsb first, stop bit, one bit per
// three ticks. The status shows the state after the current tick.
// ----------------------------------------------------------------------------
module tdu_tx #(
    parameter int unsigned DATA_BITS = tdu_pkg::DATA_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_send_request,
    input  logic [7:0]          i_send_byte,
    output tdu_pkg::t_tx_status o_status
);

    logic               r_active, n_active;
    tdu_pkg::t_tx_phase r_phase, n_phase;
    logic [1:0]         r_tick_count, n_tick_count;
    logic [3:0]         r_bit_pos, n_bit_pos;
    logic [7:0]         r_shift, n_shift;
    logic               r_level, n_level;
    logic               w_accepted;

    // next state for one tick: load on request, then advance one step
    always_comb begin
        n_active     = r_active;
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_bit_pos    = r_bit_pos;
        n_shift      = r_shift;
        n_level      = r_level;
        w_accepted   = 1'b0;

        if (i_send_request && !r_active) begin
            n_shift      = i_send_byte;
            n_phase      = tdu_pkg::TX_START;
            n_tick_count = 2'd0;
            n_bit_pos    = 4'd0;
            n_active     = 1'b1;
            w_accepted   = 1'b1;
        end

        if (n_active) begin
            n_tick_count = n_tick_count + 2'd1;
            if (n_tick_count == tdu_pkg::TX_BIT_TICKS) begin
                n_tick_count = 2'd0;
                case (n_phase)
                    tdu_pkg::TX_START: begin
                        n_level = 1'b0;
                        n_phase = tdu_pkg::TX_DATA;
                    end
                    tdu_pkg::TX_DATA: begin
                        n_level   = n_shift[n_bit_pos[2:0]];
                        n_bit_pos = n_bit_pos + 4'd1;
                        if (n_bit_pos >= 4'(DATA_BITS)) begin
                            n_phase = tdu_pkg::TX_STOP;
                        end
                    end
                    default: begin
                        // stop bit, and any code with no meaning
                        n_level  = 1'b1;
                        n_active = 1'b0;
                    end
                endcase
            end
        end
    end

    // state registers advance only on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_phase      <= tdu_pkg::TX_START;
            r_tick_count <= 2'd0;
            r_bit_pos    <= 4'd0;
            r_shift      <= 8'd0;
            r_level      <= 1'b1;
        end else if (i_step) begin
            r_active     <= n_active;
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_bit_pos    <= n_bit_pos;
            r_shift      <= n_shift;
            r_level      <= n_level;
        end
    end

    // status after this tick
    assign o_status.line     = n_level;
    assign o_status.busy     = n_active;
    assign o_status.accepted = w_accepted;

endmodule

FILE: hw/rtl/tdu_rx.sv
// ----------------------------------------------------------------------------
// tdu_rx
// Receive section: detects a low start level, samples the data bits and
// delivers the byte three ticks after the last one. Stop bit is not checked.
// ----------------------------------------------------------------------------
module tdu_rx #(
    parameter int unsigned DATA_BITS = tdu_pkg::DATA_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_enable,
    input  logic                i_rx_line,
    output tdu_pkg::t_rx_status o_status
);

    tdu_pkg::t_rx_phase r_phase, n_phase;
    logic [2:0]         r_tick_count, n_tick_count;
    logic [3:0]         r_bits_remaining, n_bits_remaining;
    logic [7:0]         r_shift, n_shift;
    logic [7:0]         r_last_byte, n_last_byte;
    logic               w_valid;
    logic [2:0]         w_bit_idx;

    // position of the bit being sampled
    assign w_bit_idx = 3'(4'(DATA_BITS) - r_bits_remaining);

    // next state for one tick, frozen while disabled
    always_comb begin
        n_phase          = r_phase;
        n_tick_count     = r_tick_count;
        n_bits_remaining = r_bits_remaining;
        n_shift          = r_shift;
        n_last_byte      = r_last_byte;
        w_valid          = 1'b0;

        if (i_enable) begin
            case (r_phase)
                tdu_pkg::RX_WAIT: begin
                    if (r_tick_count <= 3'd1) begin
                        n_tick_count = 3'd0;
                        n_phase      = tdu_pkg::RX_IDLE;
                        n_last_byte  = r_shift;
                        w_valid      = 1'b1;
                    end else begin
                        n_tick_count = r_tick_count - 3'd1;
                    end
                end
                tdu_pkg::RX_DATA: begin
                    if (r_tick_count <= 3'd1) begin
                        n_tick_count = tdu_pkg::RX_BIT_TICKS;
                        if (i_rx_line) begin
                            n_shift[w_bit_idx] = 1'b1;
                        end
                        if (r_bits_remaining <= 4'd1) begin
                            n_bits_remaining = 4'd0;
                            n_phase          = tdu_pkg::RX_WAIT;
                        end else begin
                            n_bits_remaining = r_bits_remaining - 4'd1;
                        end
                    end else begin
                        n_tick_count = r_tick_count - 3'd1;
                    end
                end
                default: begin
                    // idle, and any code with no meaning
                    n_phase = tdu_pkg::RX_IDLE;
                    if (!i_rx_line) begin
                        n_phase          = tdu_pkg::RX_DATA;
                        n_shift          = 8'd0;
                        n_tick_count     = tdu_pkg::RX_START_TICKS;
                        n_bits_remaining = 4'(DATA_BITS);
                    end
                end
            endcase
        end
    end

    // state registers advance only on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= tdu_pkg::RX_IDLE;
            r_tick_count     <= 3'd0;
            r_bits_remaining <= 4'd0;
            r_shift          <= 8'd0;
            r_last_byte      <= 8'd0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_tick_count     <= n_tick_count;
            r_bits_remaining <= n_bits_remaining;
            r_shift          <= n_shift;
            r_last_byte      <= n_last_byte;
        end
    end

    // status after this tick
    assign o_status.busy  = (n_phase == tdu_pkg::RX_DATA) || (n_phase == tdu_pkg::RX_WAIT);
    assign o_status.valid = w_valid;
    assign o_status.data  = n_last_byte;

endmodule

FILE: hw/rtl/tick_driven_uart_tx_rx.sv
// ----------------------------------------------------------------------------
// tick_driven_uart_tx_rx
// Uart transmitter and receiver stepped by ticks at three times the bit rate.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on i_in is one oversampling tick: the sampled
//   receive line plus an optional byte to send. Every tick yields exactly
//   one result transaction on o_out with the transmit line level, busy
//   flags, whether the send request started a frame, and receive data.
//   A request while the transmitter is busy is dropped (send_accepted 0).
//   An accepted tick is written at its edge to the result register, or
//   to the skid register while the result is held. One tick is taken per
//   cycle while i_in is not stalled; the tick state update and the result
//   are computed in a single pass between state and result registers.
//   When the receiver stalls, a two-entry output stage (result register and
//   skid register) takes one more tick; i_in is stalled only once both are
//   full, and resumes the cycle after the result is taken.
//   i_cfg_wr_en writes rx_enable (1 runs the receiver, 0 freezes it).
//   Synchronous reset sets the transmit line idle high, both sections idle,
//   the received byte to zero, rx_enable to 1, and empties the output stage.
// ----------------------------------------------------------------------------
module tick_driven_uart_tx_rx #(
    parameter int unsigned DATA_BITS = tdu_pkg::DATA_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tdu_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output tdu_pkg::t_out o_out,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data
);

    logic                r_rx_enable;
    logic                r_out_valid;
    tdu_pkg::t_out       r_out;
    logic                r_skid_valid;
    tdu_pkg::t_out       r_skid;
    logic                w_in_accept;
    logic                w_out_take;
    tdu_pkg::t_tx_status w_tx_status;
    tdu_pkg::t_rx_status w_rx_status;
    tdu_pkg::t_out       w_result;

    assign o_in_stall  = r_skid_valid;
    assign w_in_accept = i_in_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_out_stall;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_enable <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_rx_enable <= i_cfg_wr_data;
        end
    end

    // transmit section
    tdu_tx #(
        .DATA_BITS(DATA_BITS)
    ) u_tx (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_in_accept),
        .i_send_request(i_in.send_request),
        .i_send_byte   (i_in.send_byte),
        .o_status      (w_tx_status)
    );

    // receive section
    tdu_rx #(
        .DATA_BITS(DATA_BITS)
    ) u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_in_accept),
        .i_enable (r_rx_enable),
        .i_rx_line(i_in.rx_line),
        .o_status (w_rx_status)
    );

    // assemble this tick's result
    assign w_result.tx_line       = w_tx_status.line;
    assign w_result.tx_busy       = w_tx_status.busy;
    assign w_result.send_accepted = w_tx_status.accepted;
    assign w_result.rx_busy       = w_rx_status.busy;
    assign w_result.rx_valid      = w_rx_status.valid;
    assign w_result.rx_byte       = w_rx_status.data;

    // output control: result register with skid register behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_accept;
            end
        end else if (w_in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_accept) begin
                r_out <= w_result;
            end
        end else if (w_in_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
